FILE: design/sha_pkg.sv
package sha_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_LOAD,
      ST_ROUND,
      ST_FOLD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic clear_block;
      logic write_byte;
      logic [5:0] byte_addr;
      logic [7:0] byte_value;
      logic start_block;
      logic round_step;
      logic fold;
      logic reload;
      logic count_bits;
   } cmd_type;

   typedef struct packed {
      logic [5:0] fill;
      logic [63:0] bit_count;
   } status_type;

   localparam logic OP_ABSORB = 1'b0;
   localparam logic OP_FINISH = 1'b1;
   localparam logic [7:0] PAD_MARK = 8'h80;
   localparam logic [5:0] LEN_POS = 6'd56;

   localparam logic [31:0] INIT_HASH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [31:0] ROUND_K [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
      rotr = (x >> n) | (x << (32 - n));
   endfunction

endpackage

FILE: design/sha_if.sv
interface sha_req_if;
   logic valid;
   logic ready;
   logic operation;
   logic [7:0] data_byte;
   modport source (output valid, operation, data_byte, input ready);
   modport sink (input valid, operation, data_byte, output ready);
endinterface

interface sha_rsp_if;
   logic valid;
   logic ready;
   logic [31:0] digest_word;
   logic [2:0] word_index;
   logic final_word;
   modport source (output valid, digest_word, word_index, final_word, input ready);
   modport sink (input valid, digest_word, word_index, final_word, output ready);
endinterface

FILE: design/sha256_stream_hasher.sv
// Absorb beat: each byte is taken while idle; every 64th byte also starts a compression
// on the one-round-per-cycle compressor, which holds off input and so sets the byte rate.
// Finish beat: up to 55 zero-fill and 8 length bytes, one or two compressions (start,
// 64 rounds, fold), then eight result beats, one per cycle when the sink is ready.
// Synchronous active-high reset loads the initial hash and clears the bit count.
module sha256_stream_hasher (
   input logic clock,
   input logic reset,
   sha_req_if.sink req,
   sha_rsp_if.source rsp
);
   sha_pkg::cmd_type cmd;
   sha_pkg::status_type status;
   logic [5:0] round_idx;
   logic [2:0] out_idx;
   logic [31:0] out_word;

   // sequencer: owns handshakes, padding steps and round counter
   sha_control u_ctrl (
      .clock, .reset, .req, .rsp, .status, .out_word, .cmd, .round_idx, .out_idx
   );

   // datapath: buffer/schedule window, working vars, hash words, bit counter
   sha_datapath u_dp (
      .clock, .reset, .cmd, .round_idx, .out_idx, .status, .out_word
   );
endmodule

FILE: design/sha_datapath.sv
module sha_datapath (
   input logic clock,
   input logic reset,
   input sha_pkg::cmd_type cmd,
   input logic [5:0] round_idx,
   input logic [2:0] out_idx,
   output sha_pkg::status_type status,
   output logic [31:0] out_word
);
   // block buffer as 16 words, written bytewise; clear supports padding zeros
   logic [31:0] w_ff [16];
   logic [31:0] w_in [16];
   logic [31:0] h_ff [8];
   logic [31:0] h_in [8];
   logic [31:0] v_ff [8];
   logic [31:0] v_in [8];
   logic [63:0] cnt_ff;
   logic [63:0] cnt_in;

   logic [31:0] wt, s0, s1, wnew, big0, big1, ch, maj, t1, t2;

   assign wt = w_ff[0];
   assign s0 = sha_pkg::rotr(w_ff[1], 7) ^ sha_pkg::rotr(w_ff[1], 18) ^ (w_ff[1] >> 3);
   assign s1 = sha_pkg::rotr(w_ff[14], 17) ^ sha_pkg::rotr(w_ff[14], 19)
               ^ (w_ff[14] >> 10);
   assign wnew = s1 + w_ff[9] + s0 + w_ff[0];
   assign big1 = sha_pkg::rotr(v_ff[4], 6) ^ sha_pkg::rotr(v_ff[4], 11)
                 ^ sha_pkg::rotr(v_ff[4], 25);
   assign ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
   assign t1 = v_ff[7] + big1 + ch + sha_pkg::ROUND_K[round_idx] + wt;
   assign big0 = sha_pkg::rotr(v_ff[0], 2) ^ sha_pkg::rotr(v_ff[0], 13)
                 ^ sha_pkg::rotr(v_ff[0], 22);
   assign maj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
   assign t2 = big0 + maj;

   always_comb begin
      w_in = w_ff;
      v_in = v_ff;
      h_in = h_ff;
      cnt_in = cnt_ff;
      if (cmd.clear_block) begin
         for (int i = 0; i < 16; i++) w_in[i] = '0;
      end
      if (cmd.write_byte) begin
         w_in[cmd.byte_addr[5:2]][8*(3-cmd.byte_addr[1:0]) +: 8] = cmd.byte_value;
      end
      if (cmd.count_bits) cnt_in = cnt_ff + 64'd8;
      if (cmd.start_block) v_in = h_ff;
      if (cmd.round_step) begin
         // schedule window slides by one word each round
         for (int i = 0; i < 15; i++) w_in[i] = w_ff[i+1];
         w_in[15] = wnew;
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
      if (cmd.fold) begin
         for (int i = 0; i < 8; i++) h_in[i] = h_ff[i] + v_ff[i];
      end
      if (cmd.reload) begin
         h_in = sha_pkg::INIT_HASH;
         cnt_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      w_ff <= w_in;
      v_ff <= v_in;
      if (reset) begin
         h_ff <= sha_pkg::INIT_HASH;
         cnt_ff <= '0;
      end else begin
         h_ff <= h_in;
         cnt_ff <= cnt_in;
      end
   end

   assign status.fill = cnt_ff[8:3];
   assign status.bit_count = cnt_ff;
   assign out_word = h_ff[out_idx];
endmodule

FILE: design/sha_control.sv
module sha_control (
   input logic clock,
   input logic reset,
   sha_req_if.sink req,
   sha_rsp_if.source rsp,
   input sha_pkg::status_type status,
   input logic [31:0] out_word,
   output sha_pkg::cmd_type cmd,
   output logic [5:0] round_idx,
   output logic [2:0] out_idx
);
   sha_pkg::state_type state_ff, state_in;
   logic [5:0] rnd_ff, rnd_in;
   logic [3:0] pos_ff, pos_in;       // length bytes written / emit index
   logic [6:0] tail_ff, tail_in;     // next padding byte to zero
   logic fin_ff, fin_in;             // current compression is final
   logic spill_ff, spill_in;         // a second block follows
   logic rv_ff, rv_in;
   logic [31:0] rw_ff, rw_in;
   logic [2:0] ri_ff, ri_in;

   assign round_idx = rnd_ff;
   assign out_idx = pos_ff[2:0];
   assign req.ready = (state_ff == sha_pkg::ST_IDLE);
   assign rsp.valid = rv_ff;
   assign rsp.digest_word = rw_ff;
   assign rsp.word_index = ri_ff;
   assign rsp.final_word = (ri_ff == 3'd7);

   always_ff @(posedge clock) begin
      rw_ff <= rw_in;
      ri_ff <= ri_in;
      if (reset) begin
         state_ff <= sha_pkg::ST_IDLE;
         rnd_ff <= '0;
         pos_ff <= '0;
         tail_ff <= '0;
         fin_ff <= 1'b0;
         spill_ff <= 1'b0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rnd_ff <= rnd_in;
         pos_ff <= pos_in;
         tail_ff <= tail_in;
         fin_ff <= fin_in;
         spill_ff <= spill_in;
         rv_ff <= rv_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      rnd_in = rnd_ff;
      pos_in = pos_ff;
      tail_in = tail_ff;
      fin_in = fin_ff;
      spill_in = spill_ff;
      rv_in = rv_ff;
      rw_in = rw_ff;
      ri_in = ri_ff;
      cmd = '0;
      if (rsp.ready) rv_in = 1'b0;
      case (state_ff)
         sha_pkg::ST_IDLE: begin
            if (req.valid) begin
               cmd.write_byte = 1'b1;
               cmd.byte_addr = status.fill;
               if (req.operation == sha_pkg::OP_ABSORB) begin
                  cmd.byte_value = req.data_byte;
                  cmd.count_bits = 1'b1;
                  if (status.fill == 6'd63) begin
                     fin_in = 1'b0;
                     spill_in = 1'b0;
                     cmd.start_block = 1'b1;
                     rnd_in = '0;
                     state_in = sha_pkg::ST_ROUND;
                  end
               end else begin
                  cmd.byte_value = sha_pkg::PAD_MARK;
                  fin_in = 1'b1;
                  spill_in = (status.fill >= sha_pkg::LEN_POS);
                  tail_in = {1'b0, status.fill} + 7'd1;
                  pos_in = '0;
                  state_in = sha_pkg::ST_LOAD;
               end
            end
         end
         sha_pkg::ST_LOAD: begin
            // zero the tail one byte a cycle, then the length bytes; a spilling block is compressed first
            if (spill_ff) begin
               if (tail_ff < 7'd64) begin
                  cmd.write_byte = 1'b1;
                  cmd.byte_addr = tail_ff[5:0];
                  cmd.byte_value = '0;
                  tail_in = tail_ff + 7'd1;
               end else begin
                  cmd.start_block = 1'b1;
                  rnd_in = '0;
                  state_in = sha_pkg::ST_ROUND;
               end
            end else if (tail_ff < {1'b0, sha_pkg::LEN_POS}) begin
               cmd.write_byte = 1'b1;
               cmd.byte_addr = tail_ff[5:0];
               cmd.byte_value = '0;
               tail_in = tail_ff + 7'd1;
            end else if (pos_ff != 4'd8) begin
               // bit count, most significant byte first
               cmd.write_byte = 1'b1;
               cmd.byte_addr = sha_pkg::LEN_POS + {3'd0, pos_ff[2:0]};
               cmd.byte_value = status.bit_count[8*(7-pos_ff[2:0]) +: 8];
               pos_in = pos_ff + 4'd1;
            end else begin
               cmd.start_block = 1'b1;
               rnd_in = '0;
               state_in = sha_pkg::ST_ROUND;
            end
         end
         sha_pkg::ST_ROUND: begin
            cmd.round_step = 1'b1;
            rnd_in = rnd_ff + 6'd1;
            if (rnd_ff == 6'd63) state_in = sha_pkg::ST_FOLD;
         end
         sha_pkg::ST_FOLD: begin
            cmd.fold = 1'b1;
            pos_in = '0;
            if (!fin_ff) state_in = sha_pkg::ST_IDLE;
            else if (spill_ff) begin
               // cleared block needs only the length bytes
               cmd.clear_block = 1'b1;
               spill_in = 1'b0;
               tail_in = {1'b0, sha_pkg::LEN_POS};
               state_in = sha_pkg::ST_LOAD;
            end else state_in = sha_pkg::ST_EMIT;
         end
         sha_pkg::ST_EMIT: begin
            if (!rv_ff || rsp.ready) begin
               rv_in = 1'b1;
               rw_in = out_word;
               ri_in = pos_ff[2:0];
               pos_in = pos_ff + 4'd1;
               if (pos_ff == 4'd7) begin
                  cmd.reload = 1'b1;
                  pos_in = '0;
                  state_in = sha_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = sha_pkg::ST_IDLE;
      endcase
   end
endmodule

FILE: design/sha_checker.sv
module sha_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [2:0] rsp_word_index,
   input logic rsp_final_word
);
   a_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_final_word == (rsp_word_index == 3'd7)))
      else $error("final flag mismatch");
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_word_index))
      else $error("result beat dropped");
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && !rsp_final_word |=> rsp_valid
      && rsp_word_index == $past(rsp_word_index) + 3'd1)
      else $error("digest word order");
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_final_word |-> !req_ready)
      else $error("input taken mid digest");
endmodule

bind sha256_stream_hasher sha_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_word_index(rsp.word_index), .rsp_final_word(rsp.final_word)
);
